/* src/dsr_pkg.sv */
// Shared constants for the decimating sample recorder.
// Used by the top level and its port checker; no dependencies.
package dsr_pkg;

	localparam int DEF_STORE_DEPTH = 1024;
	localparam int DEF_VALUE_BITS  = 24;
	localparam int TIME_BITS       = 32;
	localparam int FACTOR_BITS     = 32;
	localparam int CFG_BITS        = 11;
	localparam int CFG_IDX_BITS    = 1;
	localparam int KIND_BITS       = 2;

	localparam logic [KIND_BITS-1:0] KIND_SAMPLE  = 2'd0;
	localparam logic [KIND_BITS-1:0] KIND_RESTART = 2'd1;
	localparam logic [KIND_BITS-1:0] KIND_READ    = 2'd2;

	localparam logic [CFG_IDX_BITS-1:0] REG_MAX_SAMPLES   = 1'b0;
	localparam logic [CFG_IDX_BITS-1:0] REG_RECORD_ENABLE = 1'b1;

	localparam logic [CFG_BITS-1:0]    MAX_SAMPLES_RESET = 11'd1000;
	localparam logic [FACTOR_BITS-1:0] FACTOR_TOP        = 32'h8000_0000;

endpackage

/* src/decimating_sample_recorder_unit.sv */
// Decimating sample recorder: top level with the sample store and its sequencer.
// Depends on dsr_pkg.
//
// Usage:
//   Input channel (in_valid / in_stall) carries one word per item: kind selects a
//   sample, a restart, or a read of one stored entry. Output channel (out_valid /
//   out_stall) returns exactly one result word per input word, in order.
//   Config port (cfg_we / cfg_index / cfg_data) writes max_samples and
//   record_enable; write only while no item is in flight.
// Sequencing:
//   Sample, restart and unused kinds: S_IDLE, then S_OUT, then the output register.
//   Read: adds S_RD, which takes the word from the registered read of the store memory.
//   A sample that hits the store limit compacts the store: one read and one
//   write-back per kept entry through the memory's ports, in S_CMP. One item is
//   worked on at a time; the next word is taken once the current result sits in
//   the output register.
// Reset: state clears at once, no memory clearing pass; the fill count marks
//   which entries are live. max_samples resets to 1000, record_enable to 1.
// Stall: a stalled result holds; the block keeps accepting one more item and
//   waits with its result until the output register frees.
module decimating_sample_recorder_unit #(
	parameter int STORE_DEPTH = dsr_pkg::DEF_STORE_DEPTH,
	parameter int VALUE_BITS  = dsr_pkg::DEF_VALUE_BITS
) (
	input  logic                                   clk,
	input  logic                                   arst_n,
	input  logic                                   cfg_we,
	input  logic [dsr_pkg::CFG_IDX_BITS-1:0]       cfg_index,
	input  logic [dsr_pkg::CFG_BITS-1:0]           cfg_data,
	input  logic                                   in_valid,
	output logic                                   in_stall,
	input  logic [dsr_pkg::KIND_BITS-1:0]          kind,
	input  logic signed [VALUE_BITS-1:0]           sample_value,
	input  logic [dsr_pkg::TIME_BITS-1:0]          elapsed_ms,
	input  logic [$clog2(STORE_DEPTH)-1:0]         read_index,
	output logic                                   out_valid,
	input  logic                                   out_stall,
	output logic                                   stored,
	output logic                                   compacted,
	output logic [$clog2(STORE_DEPTH+1)-1:0]       stored_count,
	output logic [dsr_pkg::FACTOR_BITS-1:0]        decimation_factor,
	output logic signed [VALUE_BITS-1:0]           min_value,
	output logic signed [VALUE_BITS-1:0]           max_value,
	output logic signed [VALUE_BITS-1:0]           last_value,
	output logic                                   entry_valid,
	output logic signed [VALUE_BITS-1:0]           entry_value,
	output logic [dsr_pkg::TIME_BITS-1:0]          entry_time_ms
);
	import dsr_pkg::*;

	localparam int IDX_W  = $clog2(STORE_DEPTH);
	localparam int CNT_W  = $clog2(STORE_DEPTH + 1);
	localparam int SRC_W  = CNT_W + 1;
	localparam int LIM_W  = (CNT_W > CFG_BITS) ? CNT_W : CFG_BITS;
	localparam int WORD_W = VALUE_BITS + TIME_BITS;

	localparam logic signed [VALUE_BITS-1:0] VALUE_MAX = {1'b0, {(VALUE_BITS-1){1'b1}}};
	localparam logic signed [VALUE_BITS-1:0] VALUE_MIN = {1'b1, {(VALUE_BITS-1){1'b0}}};

	typedef enum logic [1:0] {S_IDLE, S_CMP, S_RD, S_OUT} state_t;

	state_t                  state_q;
	logic [CFG_BITS-1:0]     max_samples_q;
	logic                    record_enable_q;
	logic [CNT_W-1:0]        count_q;
	logic [FACTOR_BITS-1:0]  keep_q;
	logic [FACTOR_BITS-1:0]  skip_q;
	logic signed [VALUE_BITS-1:0] min_q, max_q, latest_q;

	logic [SRC_W-1:0]        src_q;
	logic [CNT_W-1:0]        dst_q;
	logic                    pend_s1;
	logic                    res_stored_q, res_compacted_q;
	logic                    ent_valid_q;
	logic signed [VALUE_BITS-1:0] ent_value_q;
	logic [TIME_BITS-1:0]    ent_time_q;

	logic                    out_valid_q, stored_q, compacted_q, entry_valid_q;
	logic [CNT_W-1:0]        stored_count_q;
	logic [FACTOR_BITS-1:0]  factor_q;
	logic signed [VALUE_BITS-1:0] min_out_q, max_out_q, last_out_q, entry_value_q;
	logic [TIME_BITS-1:0]    entry_time_q;

	logic [WORD_W-1:0]       mem [STORE_DEPTH];
	logic [WORD_W-1:0]       rd_data_q;
	logic [IDX_W-1:0]        rd_addr;
	logic                    mem_we;
	logic [IDX_W-1:0]        mem_wa;
	logic [WORD_W-1:0]       mem_wd;

	logic                    accept;
	logic [LIM_W-1:0]        lim_raw, limit;
	logic                    below_limit;
	logic [FACTOR_BITS-1:0]  skip_next;
	logic                    keep_hit;
	logic                    append;
	logic                    cmp_issue;
	logic                    read_hit;
	logic                    out_free;
	logic [FACTOR_BITS-1:0]  keep_doubled;
	logic                    cmp_go;
	logic                    rd_go;
	state_t                  idle_next;
	logic                    out_load;

	assign accept   = in_valid && (state_q == S_IDLE);
	assign in_stall = (state_q != S_IDLE);
	assign out_free = !out_valid_q || !out_stall;
	assign out_load = (state_q == S_OUT) && out_free;

	always_comb begin
		lim_raw = LIM_W'(max_samples_q);
		limit   = lim_raw;
		if (lim_raw < LIM_W'(2))
			limit = LIM_W'(2);
		if (lim_raw > LIM_W'(STORE_DEPTH))
			limit = LIM_W'(STORE_DEPTH);
	end

	assign below_limit  = LIM_W'(count_q) < limit;
	assign skip_next    = skip_q + FACTOR_BITS'(1);
	assign keep_hit     = (skip_next == keep_q);
	assign append       = accept && (kind == KIND_SAMPLE) && record_enable_q
	                      && below_limit && keep_hit;
	assign cmp_issue    = src_q < SRC_W'(count_q);
	assign read_hit     = CNT_W'(read_index) < count_q;
	assign keep_doubled = (keep_q >= FACTOR_TOP) ? FACTOR_TOP : (keep_q << 1);
	assign cmp_go       = (kind == KIND_SAMPLE) && record_enable_q && !below_limit;
	assign rd_go        = (kind == KIND_READ) && read_hit;
	assign idle_next    = cmp_go ? S_CMP : (rd_go ? S_RD : S_OUT);

	always_comb begin
		rd_addr = read_index;
		if (state_q == S_CMP)
			rd_addr = src_q[IDX_W-1:0];
		mem_we = 1'b0;
		mem_wa = count_q[IDX_W-1:0];
		mem_wd = {sample_value, elapsed_ms};
		if (append) begin
			mem_we = 1'b1;
		end else if (state_q == S_CMP && pend_s1) begin
			mem_we = 1'b1;
			mem_wa = dst_q[IDX_W-1:0];
			mem_wd = rd_data_q;
		end
	end

	always_ff @(posedge clk) begin
		if (mem_we)
			mem[mem_wa] <= mem_wd;
		rd_data_q <= mem[rd_addr];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q         <= S_IDLE;
			max_samples_q   <= MAX_SAMPLES_RESET;
			record_enable_q <= 1'b1;
			count_q         <= '0;
			keep_q          <= FACTOR_BITS'(1);
			skip_q          <= '0;
			min_q           <= VALUE_MAX;
			max_q           <= VALUE_MIN;
			latest_q        <= '0;
			pend_s1         <= 1'b0;
			out_valid_q     <= 1'b0;
		end else begin
			if (cfg_we) begin
				case (cfg_index)
					REG_MAX_SAMPLES:   max_samples_q   <= cfg_data;
					REG_RECORD_ENABLE: record_enable_q <= cfg_data[0];
					default: ;
				endcase
			end

			if (out_load)
				out_valid_q <= 1'b1;
			else if (!out_stall)
				out_valid_q <= 1'b0;

			case (state_q)
				S_IDLE: begin
					if (accept) begin
						res_stored_q    <= append;
						res_compacted_q <= cmp_go;
						ent_valid_q     <= rd_go;
						ent_value_q     <= '0;
						ent_time_q      <= '0;
						src_q           <= '0;
						dst_q           <= '0;
						pend_s1         <= 1'b0;
						state_q         <= idle_next;
						case (kind)
							KIND_SAMPLE: begin
								latest_q <= sample_value;
								if (record_enable_q && below_limit) begin
									skip_q <= keep_hit ? '0 : skip_next;
									if (keep_hit) begin
										if (sample_value > max_q)
											max_q <= sample_value;
										if (sample_value < min_q)
											min_q <= sample_value;
										count_q <= count_q + CNT_W'(1);
									end
								end
							end
							KIND_RESTART: begin
								count_q <= '0;
								keep_q  <= FACTOR_BITS'(1);
								skip_q  <= '0;
								min_q   <= VALUE_MAX;
								max_q   <= VALUE_MIN;
							end
							default: ;
						endcase
					end
				end
				S_CMP: begin
					// read even entry src, write it back at dst in the following cycle
					pend_s1 <= cmp_issue;
					if (cmp_issue)
						src_q <= src_q + SRC_W'(2);
					if (pend_s1)
						dst_q <= dst_q + CNT_W'(1);
					if (!cmp_issue && !pend_s1) begin
						count_q <= dst_q;
						keep_q  <= keep_doubled;
						state_q <= S_OUT;
					end
				end
				S_RD: begin
					ent_value_q <= rd_data_q[WORD_W-1:TIME_BITS];
					ent_time_q  <= rd_data_q[TIME_BITS-1:0];
					state_q     <= S_OUT;
				end
				S_OUT: begin
					if (out_free) begin
						stored_q       <= res_stored_q;
						compacted_q    <= res_compacted_q;
						stored_count_q <= count_q;
						factor_q       <= keep_q;
						min_out_q      <= min_q;
						max_out_q      <= max_q;
						last_out_q     <= latest_q;
						entry_valid_q  <= ent_valid_q;
						entry_value_q  <= ent_value_q;
						entry_time_q   <= ent_time_q;
						state_q        <= S_IDLE;
					end
				end
				default: state_q <= S_IDLE;
			endcase
		end
	end

	assign out_valid         = out_valid_q;
	assign stored            = stored_q;
	assign compacted         = compacted_q;
	assign stored_count      = stored_count_q;
	assign decimation_factor = factor_q;
	assign min_value         = min_out_q;
	assign max_value         = max_out_q;
	assign last_value        = last_out_q;
	assign entry_valid       = entry_valid_q;
	assign entry_value       = entry_value_q;
	assign entry_time_ms     = entry_time_q;

endmodule

/* src/dsr_checker.sv */
// Port-level checks for the decimating sample recorder, bound to the top level.
// Depends on dsr_pkg and decimating_sample_recorder_unit.
module dsr_checker #(
	parameter int STORE_DEPTH = dsr_pkg::DEF_STORE_DEPTH,
	parameter int VALUE_BITS  = dsr_pkg::DEF_VALUE_BITS
) (
	input logic                               clk,
	input logic                               arst_n,
	input logic                               out_valid,
	input logic                               out_stall,
	input logic                               stored,
	input logic                               compacted,
	input logic [$clog2(STORE_DEPTH+1)-1:0]   stored_count,
	input logic [dsr_pkg::FACTOR_BITS-1:0]    decimation_factor,
	input logic                               entry_valid,
	input logic signed [VALUE_BITS-1:0]       entry_value,
	input logic [dsr_pkg::TIME_BITS-1:0]      entry_time_ms
);
	import dsr_pkg::*;

	// stalled result word holds
	a_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && out_stall |=> out_valid && $stable(stored_count)
		&& $stable(decimation_factor) && $stable(entry_value))
		else $error("stalled result word changed");

	a_entry_zero: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !entry_valid |-> entry_value == '0 && entry_time_ms == '0)
		else $error("entry fields nonzero without a valid entry");

	a_excl: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> !(stored && compacted))
		else $error("word both stored and compacted");

	a_factor: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> $onehot(decimation_factor))
		else $error("decimation factor not a power of two");

	a_count: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && (stored || entry_valid) |-> stored_count != '0)
		else $error("store empty after a store or valid read");

endmodule

bind decimating_sample_recorder_unit dsr_checker #(
	.STORE_DEPTH(STORE_DEPTH),
	.VALUE_BITS(VALUE_BITS)
) u_dsr_checker (.*);

/* tb/sv/decimating_sample_recorder_unit_tb.sv */
// Self-checking testbench for decimating_sample_recorder_unit: directed and random
// sample/restart/read words against an in-bench model of the store. Needs dsr_pkg.
`timescale 1ns / 1ps

module decimating_sample_recorder_unit_tb;
	import dsr_pkg::*;

	localparam int DEPTH  = DEF_STORE_DEPTH;
	localparam int VB     = DEF_VALUE_BITS;
	localparam int IDX_W  = $clog2(DEPTH);
	localparam int CNT_W  = $clog2(DEPTH + 1);

	localparam logic [KIND_BITS-1:0] KIND_UNUSED = 2'd3;
	localparam logic signed [VB-1:0] VAL_MAX = {1'b0, {(VB-1){1'b1}}};
	localparam logic signed [VB-1:0] VAL_MIN = {1'b1, {(VB-1){1'b0}}};

	localparam int WATCHDOG_LIMIT = 5000;
	localparam int HOLD_CYCLES    = 400;
	localparam int SETTLE_CYCLES  = 6;
	localparam int BLOCKS         = 4;
	localparam int WORDS_PER_BLK  = 100;

	typedef struct {
		logic                   stored;
		logic                   compacted;
		logic [CNT_W-1:0]       stored_count;
		logic [FACTOR_BITS-1:0] factor;
		logic signed [VB-1:0]   min_v;
		logic signed [VB-1:0]   max_v;
		logic signed [VB-1:0]   last_v;
		logic                   entry_valid;
		logic signed [VB-1:0]   entry_value;
		logic [TIME_BITS-1:0]   entry_time;
	} status_t;

	class recorder_scoreboard;
		logic signed [VB-1:0]   value_mem [DEPTH];
		logic [TIME_BITS-1:0]   time_mem [DEPTH];
		int unsigned            fill;
		bit [FACTOR_BITS-1:0]   keep_every;
		bit [FACTOR_BITS-1:0]   skip_cnt;
		logic signed [VB-1:0]   lo;
		logic signed [VB-1:0]   hi;
		logic signed [VB-1:0]   latest;
		bit [CFG_BITS-1:0]      max_samples;
		bit                     rec_en;
		status_t                pending[$];
		int                     errors;

		function new();
			clear_run();
			latest = '0;
			max_samples = MAX_SAMPLES_RESET;
			rec_en = 1'b1;
			errors = 0;
		endfunction

		function void clear_run();
			fill = 0;
			keep_every = 1;
			skip_cnt = 0;
			lo = VAL_MAX;
			hi = VAL_MIN;
		endfunction

		function void write_reg(logic [CFG_IDX_BITS-1:0] idx, logic [CFG_BITS-1:0] data);
			if (idx == REG_MAX_SAMPLES) begin
				max_samples = data;
			end else begin
				rec_en = data[0];
			end
		endfunction

		function void note_word(logic [KIND_BITS-1:0] k, logic signed [VB-1:0] v,
				logic [TIME_BITS-1:0] ms, logic [IDX_W-1:0] idx);
			status_t     s;
			int unsigned lim;
			int unsigned d;
			s.stored = 1'b0;
			s.compacted = 1'b0;
			s.entry_valid = 1'b0;
			s.entry_value = '0;
			s.entry_time = '0;
			lim = max_samples;
			if (lim < 2) lim = 2;
			if (lim > DEPTH) lim = DEPTH;
			case (k)
				KIND_SAMPLE: begin
					latest = v;
					if (rec_en) begin
						if (fill < lim) begin
							skip_cnt = skip_cnt + 1;
							if (skip_cnt == keep_every) begin
								if (v > hi) hi = v;
								if (v < lo) lo = v;
								value_mem[fill] = v;
								time_mem[fill] = ms;
								fill++;
								skip_cnt = 0;
								s.stored = 1'b1;
							end
						end else begin
							// keep even positions, double the factor
							d = 0;
							for (int unsigned src = 0; src < fill; src += 2) begin
								value_mem[d] = value_mem[src];
								time_mem[d] = time_mem[src];
								d++;
							end
							fill = d;
							keep_every = (keep_every >= FACTOR_TOP) ? FACTOR_TOP : keep_every * 2;
							s.compacted = 1'b1;
						end
					end
				end
				KIND_RESTART: clear_run();
				KIND_READ: begin
					if (idx < fill) begin
						s.entry_valid = 1'b1;
						s.entry_value = value_mem[idx];
						s.entry_time = time_mem[idx];
					end
				end
				default: ;
			endcase
			s.stored_count = CNT_W'(fill);
			s.factor = keep_every;
			s.min_v = lo;
			s.max_v = hi;
			s.last_v = latest;
			pending.push_back(s);
		endfunction

		function void mismatch(string name, logic signed [32:0] e, logic signed [32:0] a);
			$error("%s: expected %0d, actual %0d", name, e, a);
			errors++;
		endfunction

		function void check_word(status_t got);
			status_t e;
			if (pending.size() == 0) begin
				$error("result word with no pending expectation");
				errors++;
				return;
			end
			e = pending.pop_front();
			if (got.stored !== e.stored) mismatch("stored", e.stored, got.stored);
			if (got.compacted !== e.compacted) mismatch("compacted", e.compacted, got.compacted);
			if (got.stored_count !== e.stored_count)
				mismatch("stored_count", e.stored_count, got.stored_count);
			if (got.factor !== e.factor) mismatch("decimation_factor", e.factor, got.factor);
			if (got.min_v !== e.min_v) mismatch("min_value", e.min_v, got.min_v);
			if (got.max_v !== e.max_v) mismatch("max_value", e.max_v, got.max_v);
			if (got.last_v !== e.last_v) mismatch("last_value", e.last_v, got.last_v);
			if (got.entry_valid !== e.entry_valid)
				mismatch("entry_valid", e.entry_valid, got.entry_valid);
			if (got.entry_value !== e.entry_value)
				mismatch("entry_value", e.entry_value, got.entry_value);
			if (got.entry_time !== e.entry_time)
				mismatch("entry_time_ms", e.entry_time, got.entry_time);
		endfunction
	endclass

	logic                     clk;
	logic                     arst_n;
	logic                     cfg_we;
	logic [CFG_IDX_BITS-1:0]  cfg_index;
	logic [CFG_BITS-1:0]      cfg_data;
	logic                     in_valid;
	logic                     in_stall;
	logic [KIND_BITS-1:0]     kind;
	logic signed [VB-1:0]     sample_value;
	logic [TIME_BITS-1:0]     elapsed_ms;
	logic [IDX_W-1:0]         read_index;
	logic                     out_valid;
	logic                     out_stall;
	logic                     stored;
	logic                     compacted;
	logic [CNT_W-1:0]         stored_count;
	logic [FACTOR_BITS-1:0]   decimation_factor;
	logic signed [VB-1:0]     min_value;
	logic signed [VB-1:0]     max_value;
	logic signed [VB-1:0]     last_value;
	logic                     entry_valid;
	logic signed [VB-1:0]     entry_value;
	logic [TIME_BITS-1:0]     entry_time_ms;

	recorder_scoreboard sb;
	int unsigned        send_idle_pct;
	int unsigned        recv_idle_pct;
	bit                 long_hold;
	int                 quiet_cycles;

	decimating_sample_recorder_unit dut (
		.clk(clk), .arst_n(arst_n),
		.cfg_we(cfg_we), .cfg_index(cfg_index), .cfg_data(cfg_data),
		.in_valid(in_valid), .in_stall(in_stall),
		.kind(kind), .sample_value(sample_value), .elapsed_ms(elapsed_ms),
		.read_index(read_index),
		.out_valid(out_valid), .out_stall(out_stall),
		.stored(stored), .compacted(compacted), .stored_count(stored_count),
		.decimation_factor(decimation_factor), .min_value(min_value),
		.max_value(max_value), .last_value(last_value), .entry_valid(entry_valid),
		.entry_value(entry_value), .entry_time_ms(entry_time_ms)
	);

	initial clk = 1'b0;
	always #5 clk = ~clk;

	always begin
		@(posedge clk);
		if (long_hold) begin
			out_stall <= 1'b1;
			repeat (HOLD_CYCLES) @(posedge clk);
			long_hold = 1'b0;
		end
		out_stall <= ($urandom_range(99) < recv_idle_pct);
	end

	always @(posedge clk) begin
		status_t got;
		if (arst_n) begin
			if (in_valid && !in_stall)
				sb.note_word(kind, sample_value, elapsed_ms, read_index);
			if (out_valid && !out_stall) begin
				got.stored = stored;
				got.compacted = compacted;
				got.stored_count = stored_count;
				got.factor = decimation_factor;
				got.min_v = min_value;
				got.max_v = max_value;
				got.last_v = last_value;
				got.entry_valid = entry_valid;
				got.entry_value = entry_value;
				got.entry_time = entry_time_ms;
				sb.check_word(got);
			end
		end
	end

	always @(posedge clk) begin
		if ((in_valid && !in_stall) || (out_valid && !out_stall)) begin
			quiet_cycles <= 0;
		end else if (quiet_cycles >= WATCHDOG_LIMIT) begin
			$display("Verification failed");
			$finish;
		end else begin
			quiet_cycles <= quiet_cycles + 1;
		end
	end

	task automatic send_item(input logic [KIND_BITS-1:0] k, input logic signed [VB-1:0] v,
			input logic [TIME_BITS-1:0] ms, input logic [IDX_W-1:0] idx);
		while ($urandom_range(99) < send_idle_pct) begin
			in_valid <= 1'b0;
			@(posedge clk);
		end
		in_valid <= 1'b1;
		kind <= k;
		sample_value <= v;
		elapsed_ms <= ms;
		read_index <= idx;
		do @(posedge clk); while (in_stall);
	endtask

	task automatic drain();
		in_valid <= 1'b0;
		do @(posedge clk); while (sb.pending.size() != 0);
		repeat (SETTLE_CYCLES) @(posedge clk);
	endtask

	task automatic set_config(input logic [CFG_BITS-1:0] limit, input bit en);
		logic [CFG_BITS-1:0] en_word;
		en_word = {(CFG_BITS-1)'($urandom_range((1 << (CFG_BITS-1)) - 1)), en};
		cfg_we <= 1'b1;
		cfg_index <= REG_MAX_SAMPLES;
		cfg_data <= limit;
		@(posedge clk);
		sb.write_reg(REG_MAX_SAMPLES, limit);
		cfg_index <= REG_RECORD_ENABLE;
		cfg_data <= en_word;
		@(posedge clk);
		sb.write_reg(REG_RECORD_ENABLE, en_word);
		cfg_we <= 1'b0;
	endtask

	initial begin
		logic [CFG_BITS-1:0]  limit;
		logic signed [VB-1:0] v;
		logic [IDX_W-1:0]     idx;
		int unsigned          pick;
		int unsigned          span;
		int                   sent;
		sb = new();
		arst_n = 1'b0;
		cfg_we = 1'b0;
		cfg_index = '0;
		cfg_data = '0;
		in_valid = 1'b0;
		kind = KIND_SAMPLE;
		sample_value = '0;
		elapsed_ms = '0;
		read_index = '0;
		out_stall = 1'b0;
		long_hold = 1'b0;
		quiet_cycles = 0;
		send_idle_pct = 8;
		recv_idle_pct = 47;
		repeat (9) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// reset settings: empty read, extremes, out-of-range reads, unused kind, restart
		send_item(KIND_READ, 0, 0, 0);
		send_item(KIND_SAMPLE, VAL_MAX, 32'hFFFF_FFFF, '1);
		send_item(KIND_SAMPLE, VAL_MIN, 32'h0, 0);
		send_item(KIND_SAMPLE, 0, 32'd12345, 0);
		send_item(KIND_READ, 0, 0, 0);
		send_item(KIND_READ, 0, 0, 2);
		send_item(KIND_READ, 0, 0, 3);
		send_item(KIND_READ, 0, 0, '1);
		send_item(KIND_UNUSED, VAL_MAX, 32'hFFFF_FFFF, '1);
		send_item(KIND_RESTART, VAL_MIN, 32'hFFFF_FFFF, '1);
		send_item(KIND_READ, 0, 0, 0);

		// limit below range clamps to two; compaction then a skipped sample
		drain();
		set_config('0, 1'b1);
		for (int i = 0; i < 5; i++)
			send_item(KIND_SAMPLE, VB'(i * 300 - 600), 32'(i * 1000), 0);
		send_item(KIND_READ, 0, 0, 1);

		// limit above range clamps to depth; recording off only latches
		drain();
		set_config('1, 1'b0);
		send_item(KIND_SAMPLE, VB'(-77), 32'd5, 0);
		drain();
		set_config('1, 1'b1);
		send_item(KIND_RESTART, 0, 0, 0);
		for (int i = 0; i < 6; i++)
			send_item(KIND_SAMPLE, VB'(i * 11 - 20), 32'(i + 100), 0);

		// limit lowered under the count: repeated compaction
		drain();
		set_config(11'd3, 1'b1);
		for (int i = 0; i < 3; i++)
			send_item(KIND_SAMPLE, VB'(i), 32'(i + 500), 0);
		send_item(KIND_READ, 0, 0, 1);

		for (int phase = 0; phase < 3; phase++) begin
			send_idle_pct = (phase == 0) ? 8 : (phase == 1) ? 47 : 0;
			recv_idle_pct = (phase == 0) ? 47 : (phase == 1) ? 8 : 0;
			for (int blk = 0; blk < BLOCKS; blk++) begin
				drain();
				pick = $urandom_range(99);
				if (pick < 70) begin
					limit = CFG_BITS'($urandom_range(48, 2));
				end else if (pick < 88) begin
					limit = CFG_BITS'($urandom_range(300, 49));
				end else begin
					case ($urandom_range(5))
						0: limit = '0;
						1: limit = CFG_BITS'(1);
						2: limit = CFG_BITS'(2);
						3: limit = CFG_BITS'(DEPTH);
						4: limit = '1;
						default: limit = MAX_SAMPLES_RESET;
					endcase
				end
				set_config(limit, $urandom_range(99) < 88);
				sent = 0;
				while (sent < WORDS_PER_BLK) begin
					if (phase == 0 && blk == 0 && sent == 40)
						long_hold = 1'b1;
					v = VB'($urandom);
					if ($urandom_range(9) == 0)
						v = $urandom_range(1) ? VAL_MAX : VAL_MIN;
					span = (sb.fill + 1 > DEPTH - 1) ? DEPTH - 1 : sb.fill + 1;
					idx = ($urandom_range(4) == 0) ? IDX_W'($urandom_range(DEPTH - 1))
						: IDX_W'($urandom_range(span));
					pick = $urandom_range(99);
					if (pick < 70) begin
						send_item(KIND_SAMPLE, v, $urandom, idx);
						sent++;
					end else if (pick < 95) begin
						send_item(KIND_READ, v, $urandom, idx);
						sent++;
					end else if (pick < 98) begin
						send_item(KIND_RESTART, v, $urandom, idx);
						sent++;
					end else begin
						send_item(KIND_UNUSED, v, $urandom, idx);
					end
				end
			end
		end

		drain();
		repeat (20) @(posedge clk);
		if (sb.errors == 0)
			$display("Verification passed");
		else
			$display("Verification failed");
		$finish;
	end

endmodule
